// ===== design/kpc_pkg.sv =====
package kpc_pkg;

   localparam int NUM_KEYS   = 16;
   localparam int WORD_KEYS  = 16;
   localparam int CNT_W      = 8;
   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;

   localparam logic [CNT_W-1:0] DEBOUNCE_RESET = 8'd10;
   localparam logic [CNT_W-1:0] LONG_RESET     = 8'd100;
   localparam logic [CNT_W-1:0] CNT_MAX        = 8'd255;

   typedef enum logic [1:0] {
      KEY_IDLE    = 2'd0,
      KEY_PRESSED = 2'd1,
      KEY_LONG    = 2'd2
   } key_status_type;

   typedef enum logic {
      REG_DEBOUNCE = 1'b0,
      REG_LONG     = 1'b1
   } reg_index_type;

   typedef enum logic {
      ACT_LOAD = 1'b0,
      ACT_TICK = 1'b1
   } action_type;

   typedef struct packed {
      logic [CNT_W-1:0] debounce_ticks;
      logic [CNT_W-1:0] long_press_ticks;
   } cfg_type;

   typedef struct packed {
      logic       fire;
      action_type action;
      logic       key_bit;
      logic       clear_bit;
   } lane_cmd_type;

   typedef struct packed {
      key_status_type status;
      logic           short_flag;
   } lane_res_type;

endpackage

// ===== design/kpc_req_if.sv =====
interface kpc_req_if;
   logic        valid;
   logic        ready;
   logic        action;
   logic [15:0] key_bits;
   logic [15:0] clear_short_mask;

   modport source (output valid, output action, output key_bits, output clear_short_mask,
                   input ready);
   modport sink   (input valid, input action, input key_bits, input clear_short_mask,
                   output ready);
endinterface

// ===== design/kpc_rsp_if.sv =====
interface kpc_rsp_if;
   logic        valid;
   logic        ready;
   logic [31:0] key_status;
   logic [15:0] short_press_flags;

   modport source (output valid, output key_status, output short_press_flags,
                   input ready);
   modport sink   (input valid, input key_status, input short_press_flags,
                   output ready);
endinterface

// ===== design/kpc_csr.sv =====
module kpc_csr (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               psel,
   input  logic                               penable,
   input  logic                               pwrite,
   input  logic [kpc_pkg::CSR_ADDR_W-1:0]     paddr,
   input  logic [kpc_pkg::CSR_DATA_W-1:0]     pwdata,
   output logic [kpc_pkg::CSR_DATA_W-1:0]     prdata,
   output logic                               pready,
   output kpc_pkg::cfg_type                   cfg
);

   kpc_pkg::cfg_type      cfg_ff;
   kpc_pkg::cfg_type      cfg_in;
   kpc_pkg::reg_index_type reg_sel;
   logic                  wr_en;

   assign reg_sel = kpc_pkg::reg_index_type'(paddr[2]);
   assign wr_en   = psel & penable & pwrite;
   assign pready  = 1'b1;
   assign cfg     = cfg_ff;

   always_comb begin
      cfg_in = cfg_ff;
      if (wr_en) begin
         unique case (reg_sel)
            kpc_pkg::REG_DEBOUNCE: cfg_in.debounce_ticks   = pwdata[kpc_pkg::CNT_W-1:0];
            kpc_pkg::REG_LONG:     cfg_in.long_press_ticks = pwdata[kpc_pkg::CNT_W-1:0];
            default:               cfg_in = cfg_ff;
         endcase
      end
   end

   always_comb begin
      unique case (reg_sel)
         kpc_pkg::REG_DEBOUNCE: prdata = {{(kpc_pkg::CSR_DATA_W-kpc_pkg::CNT_W){1'b0}},
                                          cfg_ff.debounce_ticks};
         kpc_pkg::REG_LONG:     prdata = {{(kpc_pkg::CSR_DATA_W-kpc_pkg::CNT_W){1'b0}},
                                          cfg_ff.long_press_ticks};
         default:               prdata = '0;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.debounce_ticks   <= kpc_pkg::DEBOUNCE_RESET;
         cfg_ff.long_press_ticks <= kpc_pkg::LONG_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

endmodule

// ===== design/kpc_lane.sv =====
module kpc_lane (
   input  logic                  clock,
   input  logic                  reset,
   input  kpc_pkg::cfg_type      cfg,
   input  kpc_pkg::lane_cmd_type cmd,
   output kpc_pkg::lane_res_type res
);

   logic                         cur_ff, cur_in;
   logic                         prev_ff, prev_in;
   logic [kpc_pkg::CNT_W-1:0]    hold_ff, hold_in;
   kpc_pkg::key_status_type      status_ff, status_in;
   logic                         flag_ff, flag_in;
   logic                         reported_ff, reported_in;
   logic                         both_high;

   assign both_high = prev_ff & cur_ff;

   always_comb begin
      cur_in      = cur_ff;
      prev_in     = prev_ff;
      hold_in     = hold_ff;
      status_in   = status_ff;
      reported_in = reported_ff;
      // clear mask applies before either action
      flag_in     = flag_ff & ~cmd.clear_bit;
      if (cmd.action == kpc_pkg::ACT_LOAD) begin
         cur_in = cmd.key_bit;
      end else begin
         if (!prev_ff) begin
            hold_in = '0;
         end else if (hold_ff != kpc_pkg::CNT_MAX) begin
            hold_in = hold_ff + {{(kpc_pkg::CNT_W-1){1'b0}}, 1'b1};
         end
         if (hold_in > cfg.debounce_ticks) begin
            if (hold_in < cfg.long_press_ticks) begin
               if (both_high) begin
                  status_in = kpc_pkg::KEY_PRESSED;
                  if (!reported_ff) begin
                     flag_in     = 1'b1;
                     reported_in = 1'b1;
                  end
               end else begin
                  reported_in = 1'b0;
                  status_in   = kpc_pkg::KEY_IDLE;
               end
            end else begin
               reported_in = 1'b0;
               status_in   = both_high ? kpc_pkg::KEY_LONG : kpc_pkg::KEY_IDLE;
            end
         end
         prev_in = cur_ff;
      end
   end

   // post-step view goes to the merge stage in the same cycle
   assign res.status     = status_in;
   assign res.short_flag = flag_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_ff      <= 1'b0;
         prev_ff     <= 1'b0;
         hold_ff     <= '0;
         status_ff   <= kpc_pkg::KEY_IDLE;
         flag_ff     <= 1'b0;
         reported_ff <= 1'b0;
      end else if (cmd.fire) begin
         cur_ff      <= cur_in;
         prev_ff     <= prev_in;
         hold_ff     <= hold_in;
         status_ff   <= status_in;
         flag_ff     <= flag_in;
         reported_ff <= reported_in;
      end
   end

endmodule

// ===== design/kpc_merge.sv =====
module kpc_merge (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  kpc_pkg::lane_res_type lane_res [kpc_pkg::NUM_KEYS],
   output logic                  can_push,
   kpc_rsp_if.source             rsp_if
);

   logic [2*kpc_pkg::WORD_KEYS-1:0] status_word;
   logic [kpc_pkg::WORD_KEYS-1:0]   flag_word;

   logic                            out_valid_ff, out_valid_in;
   logic                            skid_valid_ff, skid_valid_in;
   logic [2*kpc_pkg::WORD_KEYS-1:0] out_status_ff, out_status_in;
   logic [kpc_pkg::WORD_KEYS-1:0]   out_flags_ff, out_flags_in;
   logic [2*kpc_pkg::WORD_KEYS-1:0] skid_status_ff, skid_status_in;
   logic [kpc_pkg::WORD_KEYS-1:0]   skid_flags_ff, skid_flags_in;
   logic                            pop;

   // keys above the lane count read idle with no flag
   always_comb begin
      status_word = '0;
      flag_word   = '0;
      for (int k = 0; k < kpc_pkg::NUM_KEYS; k++) begin
         status_word[2*k +: 2] = lane_res[k].status;
         flag_word[k]          = lane_res[k].short_flag;
      end
   end

   assign pop      = out_valid_ff & rsp_if.ready;
   assign can_push = ~skid_valid_ff;

   always_comb begin
      out_valid_in   = out_valid_ff;
      skid_valid_in  = skid_valid_ff;
      out_status_in  = out_status_ff;
      out_flags_in   = out_flags_ff;
      skid_status_in = skid_status_ff;
      skid_flags_in  = skid_flags_ff;
      if (skid_valid_ff) begin
         if (pop) begin
            out_status_in = skid_status_ff;
            out_flags_in  = skid_flags_ff;
            skid_valid_in = 1'b0;
         end
      end else if (!out_valid_ff || pop) begin
         out_valid_in  = push;
         out_status_in = status_word;
         out_flags_in  = flag_word;
      end else if (push) begin
         skid_valid_in  = 1'b1;
         skid_status_in = status_word;
         skid_flags_in  = flag_word;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_status_ff  <= out_status_in;
      out_flags_ff   <= out_flags_in;
      skid_status_ff <= skid_status_in;
      skid_flags_ff  <= skid_flags_in;
   end

   assign rsp_if.valid             = out_valid_ff;
   assign rsp_if.key_status        = out_status_ff;
   assign rsp_if.short_press_flags = out_flags_ff;

endmodule

// ===== design/key_press_classifier.sv =====
// Short/long press classifier for up to sixteen keys, one lane per key. Each request word
// either loads a new 16-bit key level word or applies one millisecond tick to all keys at
// once, and clears short-press flags by mask first in both cases. Every word yields exactly
// one response word carrying the 2-bit status of each key (idle, pressed, long-held) and the
// latched short-press flags as they stand after that word. A word is taken every clock cycle
// while the buffer has room; its response is registered in the output register, or in the
// skid register while that one is held. The per-lane step (an 8-bit saturating counter and
// two threshold compares) is combinational. A two-entry output buffer keeps the request side
// open while a response waits to be taken. The thresholds sit at byte addresses 0 (debounce)
// and 4 (long press) and should be written only while no word is in flight.
module key_press_classifier (
   input  logic                           clock,
   input  logic                           reset,
   kpc_req_if.sink                        req_if,
   kpc_rsp_if.source                      rsp_if,
   input  logic                           psel,
   input  logic                           penable,
   input  logic                           pwrite,
   input  logic [kpc_pkg::CSR_ADDR_W-1:0] paddr,
   input  logic [kpc_pkg::CSR_DATA_W-1:0] pwdata,
   output logic [kpc_pkg::CSR_DATA_W-1:0] prdata,
   output logic                           pready
);

   kpc_pkg::cfg_type      cfg;
   kpc_pkg::lane_res_type lane_res [kpc_pkg::NUM_KEYS];
   logic                  can_push;
   logic                  req_fire;

   assign req_if.ready = can_push;
   assign req_fire     = req_if.valid & can_push;

   kpc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .cfg     (cfg)
   );

   for (genvar k = 0; k < kpc_pkg::NUM_KEYS; k++) begin : g_lane
      kpc_pkg::lane_cmd_type cmd;

      assign cmd.fire      = req_fire;
      assign cmd.action    = kpc_pkg::action_type'(req_if.action);
      assign cmd.key_bit   = req_if.key_bits[k];
      assign cmd.clear_bit = req_if.clear_short_mask[k];

      kpc_lane u_lane (
         .clock (clock),
         .reset (reset),
         .cfg   (cfg),
         .cmd   (cmd),
         .res   (lane_res[k])
      );
   end

   kpc_merge u_merge (
      .clock    (clock),
      .reset    (reset),
      .push     (req_fire),
      .lane_res (lane_res),
      .can_push (can_push),
      .rsp_if   (rsp_if)
   );

endmodule

// ===== design/kpc_checker.sv =====
module kpc_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_ready,
   input logic        rsp_valid,
   input logic        rsp_ready,
   input logic [31:0] rsp_key_status
);

   // a stalled response stays offered
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("response dropped while stalled");

   // no key ever reports the unused status code
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((rsp_key_status & (rsp_key_status >> 1) & 32'h5555_5555) == 32'h0))
      else $error("key status code 3 seen");

   // request side only closes when the output register is full
   assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("request stalled with empty output");

   // buffer empties on reset
   assert property (@(posedge clock)
      $past(reset) |-> (!rsp_valid && req_ready))
      else $error("buffer not empty after reset");

endmodule

bind key_press_classifier kpc_checker u_kpc_checker (
   .clock          (clock),
   .reset          (reset),
   .req_ready      (req_if.ready),
   .rsp_valid      (rsp_if.valid),
   .rsp_ready      (rsp_if.ready),
   .rsp_key_status (rsp_if.key_status)
);
